[rtl/assert_macros.svh]
// Assertion helpers for the RTL. Both expect clk in scope; PDFE_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PDFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PDFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pdfe_pkg.sv]
package pdfe_pkg;

    localparam int AXIS_W      = 27;
    localparam int MAG_W       = 26;
    localparam int WORD_W      = 16;
    localparam int REM_W       = 10;
    localparam int MODE_W      = 2;
    localparam int PKT_IDX_W   = 2;
    localparam int PKT_COUNT   = 3;
    localparam int PKT_W       = 64;
    localparam int REPORT_LEN  = 21;
    localparam int PKT_DATA    = 7;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 64;

    // Input beat layout, lowest bit up.
    localparam int MODE_LSB    = 0;
    localparam int WC_LSB      = 2;
    localparam int AX1_LSB     = 3;
    localparam int AX2_LSB     = 30;
    localparam int AX3_LSB     = 57;
    localparam int FEED_LSB    = 84;
    localparam int SPIN_LSB    = 100;

    localparam logic [7:0] HDR_B0    = 8'hFE;
    localparam logic [7:0] HDR_B1    = 8'hFD;
    localparam logic [7:0] HDR_B2    = 8'h0C;
    localparam logic [7:0] REPORT_ID = 8'h06;
    localparam logic [WORD_W-1:0] FRAC_SIGN = 16'h8000;

    localparam logic [PKT_IDX_W-1:0] PKT_FIRST = 2'd0;
    localparam logic [PKT_IDX_W-1:0] PKT_LAST  = 2'd2;

    // Largest magnitude shown: 65535.999
    localparam logic [AXIS_W-1:0] AXIS_SAT_MILLI = 27'd65535999;
    localparam logic [REM_W-1:0]  MILLI_PER_UNIT = 10'd1000;
    localparam logic [3:0]        FRAC_SCALE     = 4'd10;

    // Exact divide by 1000 for any 26-bit value: ceil(2^36 / 1000), shift 36
    localparam int           RECIP_SHIFT = 36;
    localparam int           RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] AXIS_RECIP = 27'd68719477;

    typedef logic [PKT_COUNT-1:0][PKT_W-1:0] frame_t;

endpackage

[rtl/pendant_display_frame_encoder.sv]
// Pendant display frame encoder. Each input beat is one display update; the
// block turns it into the 21-byte display report (header FE FD 0C, flag byte,
// three axes as 16-bit integer part plus signed 16-bit fraction in
// ten-thousandths, feed and spindle words, pad byte), cut into three 8-byte
// packets led by 0x06. When the packets match the last frame sent, the update
// is dropped and nothing is emitted; otherwise the frame is stored and the
// three packets go out as three beats, packet number on tuser and tlast on
// the third. Axis magnitudes above 65535.999 clamp. The first update after
// reset is always sent. An update passes the raw, quotient and output
// registers before its first packet beat appears. An update that changes
// the frame occupies the output for three beats; unchanged updates pass at
// one per cycle while no changed update waits ahead of them for the output.
// Two input stages (raw register, then quotient register) hold updates while
// the output is busy, so the input keeps accepting until both are full.
module pendant_display_frame_encoder
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // indicator_mode[1:0], workpiece_coords, axis_one_milli[26:0],
    // axis_two_milli[26:0], axis_three_milli[26:0], feed_rate[15:0],
    // spindle_speed[15:0], zero fill
    input  logic [pdfe_pkg::S_TDATA_W-1:0]   s_axis_tdata,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // report_id, data_byte_1 .. data_byte_7
    output logic [pdfe_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // packet_number[1:0]
    output logic [pdfe_pkg::PKT_IDX_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import pdfe_pkg::*;
    `include "assert_macros.svh"

    // Stage one: raw update
    logic                       s1_valid_reg;
    logic [MODE_W-1:0]          s1_mode_reg;
    logic                       s1_wc_reg;
    logic signed [AXIS_W-1:0]   s1_axis_reg [PKT_COUNT];
    logic [WORD_W-1:0]          s1_feed_reg;
    logic [WORD_W-1:0]          s1_spin_reg;

    // Stage two: quotients (inside the axis units) and pass-through fields
    logic                       s2_valid_reg;
    logic [MODE_W-1:0]          s2_mode_reg;
    logic                       s2_wc_reg;
    logic [WORD_W-1:0]          s2_feed_reg;
    logic [WORD_W-1:0]          s2_spin_reg;

    // Output side
    logic                       out_valid_reg;
    logic [PKT_IDX_W-1:0]       pkt_idx_reg;
    frame_t                     out_frame_reg;
    frame_t                     last_frame_reg;

    logic [WORD_W-1:0]          ax_int  [PKT_COUNT];
    logic [WORD_W-1:0]          ax_frac [PKT_COUNT];
    logic [7:0]                 rep [REPORT_LEN];
    frame_t                     frame_next;

    logic                       s_accept;
    logic                       m_beat;
    logic                       out_free;
    logic                       s2_diff;
    logic                       s2_go;
    logic                       s2_emit;
    logic                       s1_go;

    // Handshake chain: each stage advances when the one after it has room
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_beat   = m_axis_tvalid && m_axis_tready;
    assign out_free = !out_valid_reg || (m_beat && (pkt_idx_reg == PKT_LAST));
    assign s2_diff  = (frame_next != last_frame_reg);
    assign s2_go    = s2_valid_reg && (!s2_diff || out_free);
    assign s2_emit  = s2_go && s2_diff;
    assign s1_go    = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign s_axis_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
                s2_valid_reg <= 1'b1;
            else if (s2_go)
                s2_valid_reg <= 1'b0;
        end
    end

    // Capture the raw fields of an accepted beat
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_mode_reg    <= s_axis_tdata[MODE_LSB +: MODE_W];
            s1_wc_reg      <= s_axis_tdata[WC_LSB];
            s1_axis_reg[0] <= s_axis_tdata[AX1_LSB +: AXIS_W];
            s1_axis_reg[1] <= s_axis_tdata[AX2_LSB +: AXIS_W];
            s1_axis_reg[2] <= s_axis_tdata[AX3_LSB +: AXIS_W];
            s1_feed_reg    <= s_axis_tdata[FEED_LSB +: WORD_W];
            s1_spin_reg    <= s_axis_tdata[SPIN_LSB +: WORD_W];
        end
        if (s1_go)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_wc_reg   <= s1_wc_reg;
            s2_feed_reg <= s1_feed_reg;
            s2_spin_reg <= s1_spin_reg;
        end
    end

    // One divide-by-1000 unit per axis, registered across the stage boundary
    for (genvar a = 0; a < PKT_COUNT; a++)
    begin : g_axis
        pdfe_axis_conv u_conv
        (
            .clk        (clk),
            .load       (s1_go),
            .raw        (s1_axis_reg[a]),
            .whole_part (ax_int[a]),
            .frac_part  (ax_frac[a])
        );
    end

    // Assemble the report, little-endian words, then cut it into packets
    always_comb
    begin
        rep[0]  = HDR_B0;
        rep[1]  = HDR_B1;
        rep[2]  = HDR_B2;
        rep[3]  = {s2_wc_reg, 5'b0, s2_mode_reg};
        for (int a = 0; a < PKT_COUNT; a++)
        begin
            rep[4 + 4*a] = ax_int[a][7:0];
            rep[5 + 4*a] = ax_int[a][15:8];
            rep[6 + 4*a] = ax_frac[a][7:0];
            rep[7 + 4*a] = ax_frac[a][15:8];
        end
        rep[16] = s2_feed_reg[7:0];
        rep[17] = s2_feed_reg[15:8];
        rep[18] = s2_spin_reg[7:0];
        rep[19] = s2_spin_reg[15:8];
        rep[20] = 8'h00;

        for (int k = 0; k < PKT_COUNT; k++)
        begin
            frame_next[k][7:0] = REPORT_ID;
            for (int j = 0; j < PKT_DATA; j++)
                frame_next[k][8*(j+1) +: 8] = rep[PKT_DATA*k + j];
        end
    end

    // Store a changed frame and start its three beats; step through packets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pkt_idx_reg    <= PKT_FIRST;
            last_frame_reg <= '0;
        end
        else if (s2_emit)
        begin
            out_valid_reg  <= 1'b1;
            pkt_idx_reg    <= PKT_FIRST;
            last_frame_reg <= frame_next;
        end
        else if (m_beat)
        begin
            if (pkt_idx_reg == PKT_LAST)
            begin
                out_valid_reg <= 1'b0;
                pkt_idx_reg   <= PKT_FIRST;
            end
            else
                pkt_idx_reg <= pkt_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_emit)
            out_frame_reg <= frame_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_frame_reg[pkt_idx_reg];
    assign m_axis_tuser  = pkt_idx_reg;
    assign m_axis_tlast  = (pkt_idx_reg == PKT_LAST);

    `PDFE_ASSERT(a_stored_matches_sent,
        s2_emit |=> (last_frame_reg == out_frame_reg),
        "stored frame differs from frame being sent")
    `PDFE_ASSERT(a_last_restarts,
        (m_beat && m_axis_tlast) && !s2_emit |=> !m_axis_tvalid && (pkt_idx_reg == PKT_FIRST),
        "output did not go idle after last packet")
    `PDFE_ASSERT(a_emit_only_when_free,
        s2_emit |-> out_free,
        "new frame loaded over packets not yet sent")
    `PDFE_ASSERT_ALWAYS(a_reset_quiet,
        !rst_n |=> !m_axis_tvalid,
        "output valid straight after reset")

endmodule

[rtl/pdfe_axis_conv.sv]
module pdfe_axis_conv
(
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [pdfe_pkg::AXIS_W-1:0] raw,
    output logic [pdfe_pkg::WORD_W-1:0]       whole_part,
    output logic [pdfe_pkg::WORD_W-1:0]       frac_part
);
    import pdfe_pkg::*;

    logic [AXIS_W-1:0]          raw_u;
    logic                       neg;
    logic [AXIS_W-1:0]          mag_full;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+RECIP_W-1:0]   prod;
    logic [WORD_W-1:0]          quot;

    logic [WORD_W-1:0]          quot_reg;
    logic [REM_W-1:0]           mag_lo_reg;
    logic                       neg_reg;

    logic [REM_W-1:0]           rem;
    logic [WORD_W-2:0]          frac_mag;

    // Magnitude, saturated, then the quotient by reciprocal multiply
    assign raw_u    = raw;
    assign neg      = raw_u[AXIS_W-1];
    assign mag_full = neg ? (AXIS_W'(0) - raw_u) : raw_u;
    assign mag      = (mag_full > AXIS_SAT_MILLI) ? AXIS_SAT_MILLI[MAG_W-1:0]
                                                  : mag_full[MAG_W-1:0];
    assign prod     = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, AXIS_RECIP};
    assign quot     = prod[RECIP_SHIFT +: WORD_W];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg   <= quot;
            mag_lo_reg <= mag[REM_W-1:0];
            neg_reg    <= neg;
        end
    end

    // Remainder lies below 1024, so the low ten bits carry it exactly
    assign rem        = mag_lo_reg - REM_W'(quot_reg[REM_W-1:0] * MILLI_PER_UNIT);
    assign frac_mag   = (WORD_W-1)'(rem * FRAC_SCALE);
    assign whole_part = quot_reg;
    assign frac_part  = {neg_reg, frac_mag} | (neg_reg ? FRAC_SIGN : WORD_W'(0));

endmodule

[verif/pendant_display_frame_encoder_test.sv]
module pendant_display_frame_encoder_test;

    import pdfe_pkg::*;

    // Indicator flags carried in the low bits of the flag byte.
    typedef enum logic [MODE_W-1:0]
    {
        MODE_CONTINUOUS = 2'd0,
        MODE_STEP       = 2'd1,
        MODE_PERCENT    = 2'd2,
        MODE_UNKNOWN    = 2'd3
    } indicator_mode_e;

    // How the two sides of the block idle during a stretch of the run.
    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_phase_e;

    // One display update, as the block sees it on its input.
    typedef struct packed
    {
        logic [MODE_W-1:0]        mode;
        logic                     workpiece;
        logic signed [AXIS_W-1:0] axis_one;
        logic signed [AXIS_W-1:0] axis_two;
        logic signed [AXIS_W-1:0] axis_three;
        logic signed [WORD_W-1:0] feed;
        logic signed [WORD_W-1:0] spindle;
    } update_t;

    // One packet beat as it should leave the block.
    typedef struct packed
    {
        logic [M_TDATA_W-1:0] data;
        logic [PKT_IDX_W-1:0] number;
        logic                 last;
    } packet_t;

    // A row of the directed table: the update, and where it is obvious, the
    // three packets written out by hand.
    typedef struct
    {
        update_t u;
        bit      typed;
        frame_t  typed_frame;
    } stim_row_t;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 108;
    localparam int HOLD_OFF      = 80;
    localparam int MAX_PRINTED   = 30;
    localparam int AXIS_EDGES[8] = '{65535999, -65535999, 65536000, -65536000,
                                     67108863, -67108864, 0, -1};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [PKT_IDX_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    // Frame last sent by the block, as the predictor tracks it.
    frame_t      shown_frame = '0;
    packet_t     awaited_packets[$];
    stim_row_t   directed_rows[$];
    idle_phase_e idle_phase = IDLE_NONE;
    int          hold_ask = 0;
    int          mismatch_count = 0;

    pendant_display_frame_encoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // Safety net: end the run if the handshakes ever lock up.
    initial
    begin
        #(2 * HALF_PERIOD * 400000);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Four report bytes of one axis: integer part, then the fraction in
    // ten-thousandths with the sign in bit 15. Clamp magnitudes beyond
    // 65535.999, keeping the sign; the most negative input clamps as well.
    function automatic logic [31:0] axis_word(input logic [AXIS_W-1:0] raw);
        int unsigned mag;
        logic [WORD_W-1:0] whole;
        logic [WORD_W-1:0] frac;
        mag = raw[AXIS_W-1] ? 32'h0800_0000 - 32'(raw) : 32'(raw);
        if (mag > 32'd65535999)
            mag = 32'd65535999;
        whole = WORD_W'(mag / 1000);
        frac  = WORD_W'((mag % 1000) * 10);
        if (raw[AXIS_W-1])
            frac = frac | FRAC_SIGN;
        return {frac, whole};
    endfunction

    // Build the 21-byte report, little-endian throughout, and cut it into
    // three packets of seven bytes each behind the report id.
    function automatic frame_t encode_frame(input update_t u);
        logic [8*REPORT_LEN-1:0] report;
        frame_t f;
        report = {8'h00, u.spindle, u.feed, axis_word(u.axis_three),
                  axis_word(u.axis_two), axis_word(u.axis_one),
                  u.workpiece, 5'b0, u.mode, HDR_B2, HDR_B1, HDR_B0};
        for (int k = 0; k < PKT_COUNT; k++)
            f[k] = {report[8*PKT_DATA*k +: 8*PKT_DATA], REPORT_ID};
        return f;
    endfunction

    // Called once per accepted beat. An unchanged frame is dropped by the
    // block, so queue nothing for it.
    function automatic bit accept_update(input update_t u, input bit typed,
                                         input frame_t typed_frame);
        frame_t f;
        packet_t p;
        f = encode_frame(u);
        if (f == shown_frame)
            return 1'b0;
        shown_frame = f;
        for (int k = 0; k < PKT_COUNT; k++)
        begin
            p.data   = typed ? typed_frame[k] : f[k];
            p.number = PKT_IDX_W'(k);
            p.last   = (PKT_IDX_W'(k) == PKT_LAST);
            awaited_packets.push_back(p);
        end
        return 1'b1;
    endfunction

    function automatic int idle_percent();
        case (idle_phase)
            IDLE_SENDER, IDLE_RECEIVER: return 52;
            IDLE_BOTH:                  return 33;
            default:                    return 0;
        endcase
    endfunction

    // Entered and left at a falling edge. Idle first if the phase asks for
    // it, then hold the beat until the block takes it.
    task automatic offer(input update_t u, input bit typed, input frame_t typed_frame,
                         output bit changed);
        bit sender_idles;
        sender_idles = (idle_phase == IDLE_SENDER) || (idle_phase == IDLE_BOTH);
        while (sender_idles && $urandom_range(99) < idle_percent())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, u.spindle, u.feed, u.axis_three, u.axis_two,
                          u.axis_one, u.workpiece, u.mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        changed = accept_update(u, typed, typed_frame);
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued packet has been seen.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_packets.size() != 0);
    endtask

    task automatic add_row(input indicator_mode_e mode, input bit workpiece,
                           input int ax1, input int ax2, input int ax3,
                           input int feed, input int spindle,
                           input bit typed, input frame_t typed_frame);
        stim_row_t r;
        r.u = '{mode, workpiece, AXIS_W'(ax1), AXIS_W'(ax2), AXIS_W'(ax3),
                WORD_W'(feed), WORD_W'(spindle)};
        r.typed = typed;
        r.typed_frame = typed_frame;
        directed_rows.push_back(r);
    endtask

    // Mostly in range, with some small values, some edges and some raw
    // 27-bit patterns that go past the clamp.
    function automatic logic [AXIS_W-1:0] random_axis();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return AXIS_W'($urandom);
        if (pick < 25)
            return AXIS_W'(int'($urandom_range(4000)) - 2000);
        if (pick < 32)
            return AXIS_W'(AXIS_EDGES[$urandom_range(7)]);
        return AXIS_W'(int'($urandom_range(131071998)) - 65535999);
    endfunction

    function automatic update_t random_update(input update_t prev);
        update_t n;
        int unsigned pick;
        pick = $urandom_range(99);
        n = prev;
        // Repeat the last update now and then so that the drop path is used.
        if (pick < 12)
            return n;
        // Change a single field and keep the rest.
        if (pick < 30)
        begin
            case ($urandom_range(6))
                0: n.mode       = MODE_W'($urandom_range(3));
                1: n.workpiece  = ~n.workpiece;
                2: n.axis_one   = random_axis();
                3: n.axis_two   = random_axis();
                4: n.axis_three = random_axis();
                5: n.feed       = WORD_W'($urandom);
                default: n.spindle = WORD_W'($urandom);
            endcase
            return n;
        end
        n.mode       = MODE_W'($urandom_range(3));
        n.workpiece  = 1'($urandom_range(1));
        n.axis_one   = random_axis();
        n.axis_two   = random_axis();
        n.axis_three = random_axis();
        n.feed       = WORD_W'($urandom);
        n.spindle    = WORD_W'($urandom);
        return n;
    endfunction

    // Receiver: random stalls by phase, plus a long hold-off on request that
    // is counted here so the sender can keep offering meanwhile.
    initial
    begin
        int hold_left;
        bit stalls;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            stalls = (idle_phase == IDLE_RECEIVER) || (idle_phase == IDLE_BOTH);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= !(stalls && $urandom_range(99) < idle_percent());
        end
    end

    // Compare every packet beat against the oldest expectation.
    always @(posedge clk)
    begin
        packet_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_packets.size() == 0)
                flag_mismatch($sformatf("beat %h with nothing awaited", m_axis_tdata));
            else
            begin
                want = awaited_packets.pop_front();
                for (int b = 0; b < 8; b++)
                    if (m_axis_tdata[8*b +: 8] !== want.data[8*b +: 8])
                        flag_mismatch($sformatf("%s got %h want %h",
                            (b == 0) ? "report_id" : $sformatf("data_byte_%0d", b),
                            m_axis_tdata[8*b +: 8], want.data[8*b +: 8]));
                if (m_axis_tuser !== want.number)
                    flag_mismatch($sformatf("packet_number got %0d want %0d",
                                            m_axis_tuser, want.number));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("last_packet got %b want %b",
                                            m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin
        update_t prev;
        bit      changed;
        int      sent;
        frame_t  none;
        none = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First update after reset: all zero fields, only the headers show.
        add_row(MODE_CONTINUOUS, 1'b0, 0, 0, 0, 0, 0, 1'b1,
                {64'h06, 64'h06, 64'h00000000_0CFDFE06});
        // Same again: unchanged frame, nothing out.
        add_row(MODE_CONTINUOUS, 1'b0, 0, 0, 0, 0, 0, 1'b0, none);
        // Largest positive values everywhere.
        add_row(MODE_UNKNOWN, 1'b1, 65535999, 65535999, 65535999, 32767, 32767, 1'b1,
                {64'h007FFF7F_FF270606, 64'hFFFF2706_FFFF2706, 64'h06FFFF83_0CFDFE06});
        // Largest negative values in range.
        add_row(MODE_CONTINUOUS, 1'b0, -65535999, -65535999, -65535999, -32768, -32768,
                1'b1, {64'h00800080_00A70606, 64'hFFFFA706_FFFFA706,
                       64'h06FFFF00_0CFDFE06});
        // Most negative raw input clamps onto the same frame: dropped.
        add_row(MODE_CONTINUOUS, 1'b0, -67108864, -67108864, -67108864, -32768, -32768,
                1'b0, none);
        // Most positive raw input clamps to the largest positive frame.
        add_row(MODE_UNKNOWN, 1'b1, 67108863, 67108863, 67108863, 32767, 32767,
                1'b0, none);
        // Just past the clamp on either side.
        add_row(MODE_STEP, 1'b0, 65536000, -65536000, 0, 0, 0, 1'b0, none);
        add_row(MODE_PERCENT, 1'b1, -65536000, 0, 65536000, 1, -1, 1'b0, none);
        // Fractions at their edges, and a negative value below one unit.
        add_row(MODE_STEP, 1'b0, 1, -1, 999, 0, 0, 1'b0, none);
        add_row(MODE_PERCENT, 1'b0, 1000, -1000, -999, 0, 0, 1'b0, none);
        add_row(MODE_STEP, 1'b1, 1001, 65535000, -65535001, 100, -100, 1'b0, none);
        add_row(MODE_CONTINUOUS, 1'b1, 12345678, -7654321, 0, 1234, -1, 1'b0, none);
        // Alternating bit patterns on the words.
        add_row(MODE_UNKNOWN, 1'b0, 21845, 0, 0, 21845, -21846, 1'b0, none);
        add_row(MODE_UNKNOWN, 1'b0, 43690, 21845, -43690, -21846, 21845, 1'b0, none);
        // Flag byte alone changes, then the identical update is dropped.
        add_row(MODE_PERCENT, 1'b0, 43690, 21845, -43690, -21846, 21845, 1'b0, none);
        add_row(MODE_PERCENT, 1'b0, 43690, 21845, -43690, -21846, 21845, 1'b0, none);

        idle_phase = IDLE_NONE;
        foreach (directed_rows[i])
            offer(directed_rows[i].u, directed_rows[i].typed,
                  directed_rows[i].typed_frame, changed);
        prev = directed_rows[directed_rows.size()-1].u;
        drain();

        // Random part: count only updates that change the frame.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_phase = idle_phase_e'(phase);
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                prev = random_update(prev);
                offer(prev, 1'b0, none, changed);
                if (changed)
                    sent++;
            end
            // Stall the receiver for a long stretch and keep offering, so
            // both input stages fill and the block holds off its input.
            if (phase == 0)
            begin
                hold_ask = HOLD_OFF;
                repeat (8)
                begin
                    prev = random_update(prev);
                    offer(prev, 1'b0, none, changed);
                end
            end
            drain();
        end

        idle_phase = IDLE_NONE;
        repeat (24) @(posedge clk);
        if (mismatch_count == 0 && awaited_packets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[pendant_display_frame_encoder.f]
+incdir+rtl
rtl/pdfe_pkg.sv
rtl/pdfe_axis_conv.sv
rtl/pendant_display_frame_encoder.sv
verif/pendant_display_frame_encoder_test.sv
